// ----- rtl/density_to_spectrum_rgb_macros.svh -----
`ifndef DENSITY_TO_SPECTRUM_RGB_MACROS_SVH
`define DENSITY_TO_SPECTRUM_RGB_MACROS_SVH

// same-cycle check, needs clk and rst in scope
`define DTS_HOLDS(name, pre, post) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("dts same-cycle check failed");

// next-cycle check
`define DTS_NEXT(name, pre, post) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("dts next-cycle check failed");

`endif

// ----- rtl/dts_pkg.sv -----
`timescale 1ns / 1ps

package dts_pkg;

  // segment codes
  localparam logic [2:0] SEG_VIOLET = 3'd0;  // 380..440 nm
  localparam logic [2:0] SEG_BLUE   = 3'd1;  // 440..490 nm
  localparam logic [2:0] SEG_CYAN   = 3'd2;  // 490..510 nm
  localparam logic [2:0] SEG_GREEN  = 3'd3;  // 510..580 nm
  localparam logic [2:0] SEG_YELLOW = 3'd4;  // 580..645 nm
  localparam logic [2:0] SEG_RED    = 3'd5;  // 645..780 nm

  localparam logic [16:0] D_ONE      = 17'd65536;
  localparam logic [16:0] D_VIOLET   = 17'd9830;
  localparam logic [16:0] D_BLUE     = 17'd18022;
  localparam logic [16:0] D_CYAN     = 17'd21299;
  localparam logic [16:0] D_GREEN    = 17'd32767;
  localparam logic [16:0] D_YELLOW   = 17'd43417;
  localparam logic [16:0] D_FALLOFF  = 17'd6553;

  localparam logic [19:0] FN_BASE    = 20'd196608;
  localparam logic [19:0] FN_SLOPE   = 20'd70;
  localparam logic [19:0] FN_UNITY   = 20'd655360;

  // gamma 1.0 segment: floor(n*255/110592) = ((n*255)>>12)*9710>>18
  localparam logic [26:0] LIN_RECIP  = 27'd9710;

  localparam logic [16:0] ROOT_TINY  = 17'd65;
  localparam logic [25:0] INV_CAP    = 26'd65536000;
  localparam logic [16:0] DIV_SEED   = 17'd64;

  localparam int SQRT_STEPS = 17;
  localparam int DIV_STEPS  = 26;
  localparam int GAM_STEPS  = 8;
  localparam int NCELL      = SQRT_STEPS + DIV_STEPS;

  // ratio denominators of the gamma 0.8 segments
  localparam logic [35:0] Q_R1 = 36'd32212254720;  // 49152 * 655360
  localparam logic [35:0] Q_G2 = 36'd40960;
  localparam logic [35:0] Q_B3 = 36'd16384;
  localparam logic [35:0] Q_R4 = 36'd57344;
  localparam logic [35:0] Q_G5 = 36'd53248;
  localparam logic [35:0] Q_BF = 36'd655360;

  localparam logic [191:0] FULL5 = 192'd1078203909375;  // 255^5

  typedef logic [35:0] thr_tab_t [256];

  typedef struct packed {
    logic [16:0] d;
    logic [2:0]  seg;
    logic [35:0] pa;
    logic [35:0] pb;
    logic [7:0]  ka;
    logic [7:0]  kb;
    logic [7:0]  glin;
    logic [16:0] root;
    logic [18:0] rem;
    logic [16:0] drem;
    logic [25:0] quo;
  } work_t;

  // smallest p with 255^5 * p^4 >= k^5 * q^4
  function automatic logic [35:0] thr_calc(input logic [7:0] k, input logic [35:0] q);
    logic [191:0] kk;
    logic [191:0] qq;
    logic [191:0] rhs;
    logic [191:0] pp;
    logic [191:0] lhs;
    logic [36:0]  lo;
    logic [36:0]  hi;
    logic [36:0]  mid;
    kk  = 192'(k);
    qq  = 192'(q);
    rhs = kk * kk * kk * kk * kk * qq * qq * qq * qq;
    lo  = '0;
    hi  = 37'(q);
    for (int i = 0; i < 40; i++) begin
      if (lo < hi) begin
        mid = (lo + hi) >> 1;
        pp  = 192'(mid);
        lhs = pp * pp * pp * pp * FULL5;
        if (lhs >= rhs) begin
          hi = mid;
        end else begin
          lo = mid + 37'd1;
        end
      end
    end
    return lo[35:0];
  endfunction

  function automatic thr_tab_t make_tab(input logic [35:0] q);
    thr_tab_t t;
    for (int k = 0; k < 256; k++) begin
      t[k] = thr_calc(8'(k), q);
    end
    return t;
  endfunction

  localparam thr_tab_t TAB_R1 = make_tab(Q_R1);
  localparam thr_tab_t TAB_G2 = make_tab(Q_G2);
  localparam thr_tab_t TAB_B3 = make_tab(Q_B3);
  localparam thr_tab_t TAB_R4 = make_tab(Q_R4);
  localparam thr_tab_t TAB_G5 = make_tab(Q_G5);
  localparam thr_tab_t TAB_BF = make_tab(Q_BF);

  function automatic logic [35:0] thr_a(input logic [2:0] seg, input logic [7:0] idx);
    logic [35:0] t;
    case (seg)
      SEG_VIOLET: t = TAB_R1[idx];
      SEG_BLUE:   t = TAB_G2[idx];
      SEG_CYAN:   t = TAB_B3[idx];
      SEG_GREEN:  t = TAB_R4[idx];
      SEG_YELLOW: t = TAB_G5[idx];
      default:    t = '0;
    endcase
    return t;
  endfunction

endpackage

// ----- rtl/dts_ifs.sv -----
`timescale 1ns / 1ps

interface dts_in_if;
  logic               valid;
  logic               ready;
  logic signed [17:0] density_in;

  modport source (output valid, output density_in, input ready);
  modport sink (input valid, input density_in, output ready);
endinterface

interface dts_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;
  logic [16:0] clamped_density;
  logic [16:0] root_density;
  logic [25:0] inverse_root;

  modport source (output valid, output red, output green, output blue,
                  output clamped_density, output root_density, output inverse_root,
                  input ready);
  modport sink (input valid, input red, input green, input blue,
                input clamped_density, input root_density, input inverse_root,
                output ready);
endinterface

// ----- rtl/dts_front.sv -----
`timescale 1ns / 1ps

module dts_front (
  input  logic            clk,
  input  logic            rst,
  dts_in_if.sink          sample,
  output logic            out_valid,
  input  logic            out_ready,
  output dts_pkg::work_t  out_work
);

  logic [16:0] d;
  logic [19:0] five_d;
  logic [19:0] fn;
  logic [19:0] fnb;
  logic [19:0] fna;
  logic        fac;
  logic [2:0]  seg;
  logic [19:0] num20;
  logic [35:0] pa;
  logic [16:0] lin_n;
  logic [24:0] lin_a;
  logic [26:0] lin_p;
  dts_pkg::work_t work_next;

  assign sample.ready = !out_valid || out_ready;

  always_comb begin
    if (sample.density_in[17]) begin
      d = '0;
    end else if (sample.density_in[16:0] > dts_pkg::D_ONE) begin
      d = dts_pkg::D_ONE;
    end else begin
      d = sample.density_in[16:0];
    end

    five_d = 20'({d, 2'b00}) + 20'(d);
    fn     = dts_pkg::FN_BASE + 20'(d) * dts_pkg::FN_SLOPE;
    fac    = d <= dts_pkg::D_FALLOFF;
    fnb    = fac ? fn : dts_pkg::FN_UNITY;

    if (d <= dts_pkg::D_VIOLET) begin
      seg = dts_pkg::SEG_VIOLET;
    end else if (d <= dts_pkg::D_BLUE) begin
      seg = dts_pkg::SEG_BLUE;
    end else if (d <= dts_pkg::D_CYAN) begin
      seg = dts_pkg::SEG_CYAN;
    end else if (d <= dts_pkg::D_GREEN) begin
      seg = dts_pkg::SEG_GREEN;
    end else if (d <= dts_pkg::D_YELLOW) begin
      seg = dts_pkg::SEG_YELLOW;
    end else begin
      seg = dts_pkg::SEG_RED;
    end

    case (seg)
      dts_pkg::SEG_VIOLET: num20 = 20'd49152 - five_d;
      dts_pkg::SEG_BLUE:   num20 = five_d - 20'd49152;
      dts_pkg::SEG_CYAN:   num20 = 20'd106496 - five_d;
      dts_pkg::SEG_GREEN:  num20 = five_d - 20'd106496;
      dts_pkg::SEG_YELLOW: num20 = 20'd217088 - five_d;
      default:             num20 = '0;
    endcase

    // factor only scales the violet red and blue lanes; unity factor = 655360/655360
    fna = (seg == dts_pkg::SEG_VIOLET) ? fnb : 20'd1;
    pa  = 36'(num20[15:0]) * 36'(fna);

    lin_n = 17'(five_d - 20'd217088);
    lin_a = {lin_n, 8'b0} - 25'(lin_n);
    lin_p = 27'(lin_a[24:12]) * dts_pkg::LIN_RECIP;

    work_next.d    = d;
    work_next.seg  = seg;
    work_next.pa   = pa;
    work_next.pb   = 36'(fnb);
    work_next.ka   = '0;
    work_next.kb   = '0;
    work_next.glin = lin_p[25:18];
    work_next.root = '0;
    work_next.rem  = '0;
    work_next.drem = dts_pkg::DIV_SEED;
    work_next.quo  = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (sample.ready) begin
      out_valid <= sample.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sample.ready && sample.valid) begin
      out_work <= work_next;
    end
  end

endmodule

// ----- rtl/dts_cell.sv -----
`timescale 1ns / 1ps

// One stage of the chain: a root bit (first 17 cells, where the first 8 also
// take a gamma search bit) or a reciprocal quotient bit (remaining cells).
module dts_cell #(
  parameter int STEP = 0
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  dts_pkg::work_t  in_work,
  output logic            out_valid,
  input  logic            out_ready,
  output dts_pkg::work_t  out_work
);

  logic [16:0] root_n;
  logic [18:0] rem_n;
  logic [7:0]  ka_n;
  logic [7:0]  kb_n;
  logic [16:0] drem_n;
  logic [25:0] quo_n;
  dts_pkg::work_t work_next;

  generate
    if (STEP < dts_pkg::SQRT_STEPS) begin : g_sqrt
      logic [33:0] x;
      logic [20:0] t;
      logic [20:0] trial;
      always_comb begin
        x     = {1'b0, in_work.d, 16'b0};
        t     = {in_work.rem, x[33-2*STEP -: 2]};
        trial = 21'({in_work.root, 2'b01});
        if (t >= trial) begin
          rem_n  = 19'(t - trial);
          root_n = {in_work.root[15:0], 1'b1};
        end else begin
          rem_n  = t[18:0];
          root_n = {in_work.root[15:0], 1'b0};
        end
      end
    end else begin : g_nosqrt
      assign root_n = in_work.root;
      assign rem_n  = in_work.rem;
    end

    if (STEP < dts_pkg::GAM_STEPS) begin : g_gam
      localparam logic [7:0] BIT = 8'(1 << (7 - STEP));
      logic [7:0] mid_a;
      logic [7:0] mid_b;
      always_comb begin
        mid_a = in_work.ka | BIT;
        mid_b = in_work.kb | BIT;
        ka_n  = (in_work.pa >= dts_pkg::thr_a(in_work.seg, mid_a)) ? mid_a : in_work.ka;
        kb_n  = (in_work.pb >= dts_pkg::TAB_BF[mid_b]) ? mid_b : in_work.kb;
      end
    end else begin : g_nogam
      assign ka_n = in_work.ka;
      assign kb_n = in_work.kb;
    end

    if (STEP >= dts_pkg::SQRT_STEPS) begin : g_div
      logic [17:0] t;
      always_comb begin
        t = {in_work.drem, 1'b0};
        if (t >= {1'b0, in_work.root}) begin
          drem_n = 17'(t - {1'b0, in_work.root});
          quo_n  = {in_work.quo[24:0], 1'b1};
        end else begin
          drem_n = t[16:0];
          quo_n  = {in_work.quo[24:0], 1'b0};
        end
      end
    end else begin : g_nodiv
      assign drem_n = in_work.drem;
      assign quo_n  = in_work.quo;
    end
  endgenerate

  always_comb begin
    work_next      = in_work;
    work_next.root = root_n;
    work_next.rem  = rem_n;
    work_next.ka   = ka_n;
    work_next.kb   = kb_n;
    work_next.drem = drem_n;
    work_next.quo  = quo_n;
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_work <= work_next;
    end
  end

endmodule

// ----- rtl/density_to_spectrum_rgb.sv -----
`timescale 1ns / 1ps

// channel | dir | payload
// sample  | in  | density_in (signed Q2.16)
// color   | out | red, green, blue, clamped_density, root_density, inverse_root
//
// One item per cycle while the color output is ready; front stage plus 43 chain cells
// (17 root bits, then 26 reciprocal quotient bits; gamma search in cells 0-7).
// Each stage holds its item while the next one is full; empty stages fill
// regardless, so a stalled output does not block upstream bubbles.
// Synchronous reset clears only the stage valid flags.
`include "density_to_spectrum_rgb_macros.svh"

module density_to_spectrum_rgb (
  input  logic      clk,
  input  logic      rst,
  dts_in_if.sink    sample,
  dts_out_if.source color
);

  logic           vld [dts_pkg::NCELL+1];
  logic           rdy [dts_pkg::NCELL+1];
  dts_pkg::work_t wk  [dts_pkg::NCELL+1];
  dts_pkg::work_t last;

  dts_front u_front (
    .clk       (clk),
    .rst       (rst),
    .sample    (sample),
    .out_valid (vld[0]),
    .out_ready (rdy[0]),
    .out_work  (wk[0])
  );

  generate
    for (genvar i = 0; i < dts_pkg::NCELL; i++) begin : g_cell
      dts_cell #(.STEP(i)) u_cell (
        .clk       (clk),
        .rst       (rst),
        .in_valid  (vld[i]),
        .in_ready  (rdy[i]),
        .in_work   (wk[i]),
        .out_valid (vld[i+1]),
        .out_ready (rdy[i+1]),
        .out_work  (wk[i+1])
      );
    end
  endgenerate

  assign last                  = wk[dts_pkg::NCELL];
  assign color.valid           = vld[dts_pkg::NCELL];
  assign rdy[dts_pkg::NCELL]   = color.ready;
  assign color.clamped_density = last.d;
  assign color.root_density    = last.root;
  assign color.inverse_root    = (last.root <= dts_pkg::ROOT_TINY) ? dts_pkg::INV_CAP
                                                                   : last.quo;

  always_comb begin
    unique case (last.seg)
      dts_pkg::SEG_VIOLET: begin
        color.red = last.ka; color.green = 8'd0; color.blue = last.kb;
      end
      dts_pkg::SEG_BLUE: begin
        color.red = 8'd0; color.green = last.ka; color.blue = 8'd255;
      end
      dts_pkg::SEG_CYAN: begin
        color.red = 8'd0; color.green = 8'd255; color.blue = last.ka;
      end
      dts_pkg::SEG_GREEN: begin
        color.red = last.ka; color.green = 8'd255; color.blue = 8'd0;
      end
      dts_pkg::SEG_YELLOW: begin
        color.red = 8'd255; color.green = last.ka; color.blue = 8'd0;
      end
      default: begin
        color.red = 8'd255; color.green = last.glin; color.blue = last.glin;
      end
    endcase
  end

  `DTS_NEXT(a_front_load, sample.valid && sample.ready, vld[0])
  `DTS_HOLDS(a_root_low, color.valid,
    ({17'b0, color.root_density} * {17'b0, color.root_density})
      <= {1'b0, color.clamped_density, 16'b0})
  `DTS_HOLDS(a_root_high, color.valid,
    (34'({17'b0, color.root_density} + 34'd1) * 34'({17'b0, color.root_density} + 34'd1))
      > {1'b0, color.clamped_density, 16'b0})
  `DTS_HOLDS(a_recip, color.valid && (color.root_density > dts_pkg::ROOT_TINY),
    (43'(color.inverse_root) * 43'(color.root_density)) <= 43'h100000000)

endmodule
